FILE: design/qcvr_pkg.sv
`default_nettype none

package qcvr_pkg;

   // Width of the tick timer; durations longer than its maximum are cut to it.
   localparam int TimerBits = 12;
   localparam int DurBits = 12;
   localparam int WideBits = (TimerBits > DurBits) ? TimerBits : DurBits;
   localparam logic [TimerBits-1:0] TimerMax = '1;

   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits = 12;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_INIT_HOLD = 3'd0,
      CSR_DISCHARGE = 3'd1,
      CSR_POLL      = 3'd2,
      CSR_PULSE     = 3'd3,
      CSR_REPEAT    = 3'd4
   } csr_index_type;

   localparam logic [2:0] Code5V = 3'd7;
   localparam logic [2:0] Code9V = 3'd3;
   localparam logic [2:0] Code12V = 3'd5;
   localparam logic [2:0] Code20V = 3'd1;
   localparam logic [2:0] CodeCont = 3'd6;

   localparam logic [11:0] InitHoldReset = 12'd1500;
   localparam logic [7:0] DischargeReset = 8'd50;
   localparam logic [7:0] PollReset = 8'd50;
   localparam logic [7:0] PulseReset = 8'd50;
   localparam logic [9:0] RepeatReset = 10'd255;

   typedef enum logic [3:0] {
      PH_HOLD   = 4'd0,
      PH_DISCH  = 4'd1,
      PH_POLL   = 4'd2,
      PH_REVERT = 4'd3,
      PH_PULSE  = 4'd4,
      PH_CONT   = 4'd5,
      PH_HELD   = 4'd6
   } phase_type;

   typedef struct packed {
      logic [11:0] init_hold_ticks;
      logic [7:0]  discharge_ticks;
      logic [7:0]  poll_ticks;
      logic [7:0]  pulse_ticks;
      logic [9:0]  repeat_ticks;
   } cfg_type;

   typedef struct packed {
      logic [2:0] dip_code;
      logic       inc_pressed;
      logic       dec_pressed;
   } item_type;

   typedef struct packed {
      logic       dp_high_drive;
      logic       dp_low_drive;
      logic       dm_low_drive;
      logic       dm_high_drive;
      logic [2:0] mode_code;
      logic       handshake_done;
   } result_type;

   // Cuts a duration to the largest count the timer can reach.
   function automatic logic [TimerBits-1:0] clamp_dur(input logic [DurBits-1:0] dur);
      logic [WideBits-1:0] d;
      d = WideBits'(dur);
      if (d > WideBits'(TimerMax)) begin
         d = WideBits'(TimerMax);
      end
      return TimerBits'(d);
   endfunction

endpackage

`default_nettype wire

FILE: design/qcvr_csr.sv
`default_nettype none

module qcvr_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [qcvr_pkg::CsrIndexBits-1:0]  csr_index,
   input  wire logic [qcvr_pkg::CsrDataBits-1:0]   csr_data,
   output qcvr_pkg::cfg_type                       cfg
);
   import qcvr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_INIT_HOLD: cfg_in.init_hold_ticks = csr_data[11:0];
            CSR_DISCHARGE: cfg_in.discharge_ticks = csr_data[7:0];
            CSR_POLL:      cfg_in.poll_ticks = csr_data[7:0];
            CSR_PULSE:     cfg_in.pulse_ticks = csr_data[7:0];
            CSR_REPEAT:    cfg_in.repeat_ticks = csr_data[9:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_hold_ticks <= InitHoldReset;
         cfg_ff.discharge_ticks <= DischargeReset;
         cfg_ff.poll_ticks <= PollReset;
         cfg_ff.pulse_ticks <= PulseReset;
         cfg_ff.repeat_ticks <= RepeatReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/qcvr_ctrl.sv
`default_nettype none

module qcvr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  wire qcvr_pkg::item_type   item,
   input  wire qcvr_pkg::cfg_type    cfg,
   output qcvr_pkg::result_type      result
);
   import qcvr_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [TimerBits-1:0]   tick_timer_ff, tick_timer_in;
   logic [2:0]             current_code_ff, current_code_in;
   logic [2:0]             pending_code_ff, pending_code_in;
   logic [9:0]             hold_count_ff, hold_count_in;
   logic                   step_up_ff, step_up_in;

   logic [TimerBits-1:0]   tick_sat;
   logic [DurBits-1:0]     dur;
   logic                   tdone;
   logic [9:0]             hold_next;
   logic                   held_btn;
   logic [3:0]             pat;

   function automatic logic [3:0] pattern_of(input logic [2:0] code);
      logic [3:0] p;
      case (code)
         Code9V:   p = 4'hB;
         Code12V:  p = 4'h9;
         Code20V:  p = 4'hF;
         CodeCont: p = 4'hD;
         default:  p = 4'h1;
      endcase
      return p;
   endfunction

   // Duration of the phase being timed, and whether this tick ends it.
   always_comb begin
      case (phase_ff)
         PH_HOLD:   dur = cfg.init_hold_ticks;
         PH_DISCH:  dur = DurBits'(cfg.discharge_ticks);
         PH_REVERT: dur = DurBits'(cfg.pulse_ticks);
         PH_PULSE:  dur = DurBits'(cfg.pulse_ticks);
         PH_CONT:   dur = DurBits'(cfg.pulse_ticks);
         default:   dur = DurBits'(cfg.poll_ticks);
      endcase
      tick_sat = (tick_timer_ff == TimerMax) ? TimerMax : tick_timer_ff + 1'b1;
      tdone = tick_sat >= clamp_dur(dur);
      hold_next = hold_count_ff + 10'd1;
      held_btn = step_up_ff ? item.inc_pressed : item.dec_pressed;
   end

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      tick_timer_in = tick_timer_ff;
      current_code_in = current_code_ff;
      pending_code_in = pending_code_ff;
      hold_count_in = hold_count_ff;
      step_up_in = step_up_ff;
      if (step_en) begin
         unique case (phase_ff)
            PH_HOLD: begin
               tick_timer_in = tdone ? '0 : tick_sat;
               if (tdone) phase_in = PH_DISCH;
            end
            PH_DISCH: begin
               tick_timer_in = tdone ? '0 : tick_sat;
               if (tdone) begin
                  current_code_in = item.dip_code;
                  phase_in = PH_POLL;
               end
            end
            PH_REVERT: begin
               tick_timer_in = tdone ? '0 : tick_sat;
               if (tdone) begin
                  current_code_in = pending_code_ff;
                  phase_in = PH_POLL;
               end
            end
            PH_PULSE: begin
               tick_timer_in = tdone ? '0 : tick_sat;
               if (tdone) phase_in = PH_CONT;
            end
            PH_CONT: begin
               tick_timer_in = tdone ? '0 : tick_sat;
               if (tdone) begin
                  phase_in = PH_HELD;
                  hold_count_in = '0;
               end
            end
            PH_HELD: begin
               if (!held_btn) begin
                  phase_in = PH_POLL;
                  tick_timer_in = '0;
               end else if (hold_next >= cfg.repeat_ticks || hold_next == '0) begin
                  // A repeat count of zero behaves like one.
                  hold_count_in = '0;
                  phase_in = PH_PULSE;
                  tick_timer_in = '0;
               end else begin
                  hold_count_in = hold_next;
               end
            end
            default: begin
               phase_in = PH_POLL;
               tick_timer_in = tdone ? '0 : tick_sat;
               if (tdone) begin
                  if (item.dip_code != current_code_ff && current_code_ff == CodeCont) begin
                     pending_code_in = item.dip_code;
                     phase_in = PH_REVERT;
                  end else begin
                     current_code_in = item.dip_code;
                     if (item.dip_code == CodeCont) begin
                        if (item.inc_pressed) begin
                           step_up_in = 1'b1;
                           phase_in = PH_PULSE;
                        end else if (item.dec_pressed) begin
                           step_up_in = 1'b0;
                           phase_in = PH_PULSE;
                        end
                     end
                  end
               end
            end
         endcase
      end
   end

   // Result for the state after this tick.
   always_comb begin
      result.handshake_done = 1'b1;
      unique case (phase_in)
         PH_HOLD: begin
            pat = 4'h9;
            result.mode_code = current_code_in;
            result.handshake_done = 1'b0;
         end
         PH_DISCH: begin
            pat = 4'h1;
            result.mode_code = current_code_in;
            result.handshake_done = 1'b0;
         end
         PH_REVERT: begin
            result.mode_code = Code5V;
            pat = pattern_of(Code5V);
         end
         PH_PULSE: begin
            result.mode_code = step_up_in ? Code20V : Code12V;
            pat = pattern_of(result.mode_code);
         end
         PH_CONT: begin
            result.mode_code = CodeCont;
            pat = pattern_of(CodeCont);
         end
         default: begin
            result.mode_code = current_code_in;
            pat = pattern_of(current_code_in);
         end
      endcase
      result.dp_high_drive = pat[0];
      result.dp_low_drive = pat[1];
      result.dm_low_drive = pat[2];
      result.dm_high_drive = pat[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HOLD;
         tick_timer_ff <= '0;
         current_code_ff <= Code5V;
         pending_code_ff <= Code5V;
         hold_count_ff <= '0;
         step_up_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         tick_timer_ff <= tick_timer_in;
         current_code_ff <= current_code_in;
         pending_code_ff <= pending_code_in;
         hold_count_ff <= hold_count_in;
         step_up_ff <= step_up_in;
      end
   end

   // The start handshake never comes back once it is over.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_HOLD && phase_ff != PH_DISCH)
      |=> (phase_ff != PH_HOLD && phase_ff != PH_DISCH))
      else $error("start handshake re-entered");

   // Steps only run while continuous mode is selected.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PULSE || phase_ff == PH_CONT || phase_ff == PH_HELD)
      |-> current_code_ff == CodeCont)
      else $error("step outside continuous mode");

   // A tick that is not taken leaves the state alone.
   assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(phase_ff) && $stable(tick_timer_ff) && $stable(current_code_ff))
      else $error("state moved without a tick");

endmodule

`default_nettype wire

FILE: design/quick_charge_voltage_requester_unit.sv
`default_nettype none
// A tick beat accepted into the input register moves through the sequencer into the result register.
// Throughput: one tick beat per clock while the result side keeps taking beats; the input and
// result registers hold one beat each, so a tick is taken while a finished result waits.
// Reset (synchronous, active high): all timing registers take their defaults, the
// sequencer restarts the start handshake and both pipeline registers empty.

module quick_charge_voltage_requester_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [2:0]                         req_dip_code,
   input  wire logic                               req_inc_pressed,
   input  wire logic                               req_dec_pressed,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_dp_high_drive,
   output logic                                    rsp_dp_low_drive,
   output logic                                    rsp_dm_low_drive,
   output logic                                    rsp_dm_high_drive,
   output logic [2:0]                              rsp_mode_code,
   output logic                                    rsp_handshake_done,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [qcvr_pkg::CsrIndexBits-1:0]  csr_index,
   input  wire logic [qcvr_pkg::CsrDataBits-1:0]   csr_data
);
   import qcvr_pkg::*;

   cfg_type     cfg;
   item_type    item_ff, item_in;
   logic        in_valid_ff, in_valid_in;
   result_type  result;
   result_type  rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        advance;

   qcvr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   qcvr_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // The held tick moves on when the result register is free or being emptied.
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      item_in = item_ff;
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         item_in.dip_code = req_dip_code;
         item_in.inc_pressed = req_inc_pressed;
         item_in.dec_pressed = req_dec_pressed;
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_in = advance ? result : rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_dp_high_drive = rsp_ff.dp_high_drive;
   assign rsp_dp_low_drive = rsp_ff.dp_low_drive;
   assign rsp_dm_low_drive = rsp_ff.dm_low_drive;
   assign rsp_dm_high_drive = rsp_ff.dm_high_drive;
   assign rsp_mode_code = rsp_ff.mode_code;
   assign rsp_handshake_done = rsp_ff.handshake_done;

   // Every tick that leaves the input register lands in the result register.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("tick lost between stages");

   // A tick blocked by a full result register stays put.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(item_ff)))
      else $error("blocked tick dropped or changed");

   // The input side only stalls when both registers hold a beat.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff))
      else $error("input stalled with room to spare");

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import qcvr_pkg::*;

   localparam int StallLimit = 2000;
   localparam int TailCycles = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [2:0]             req_dip_code = '0;
   logic                   req_inc_pressed = 1'b0;
   logic                   req_dec_pressed = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_dp_high_drive;
   logic                   rsp_dp_low_drive;
   logic                   rsp_dm_low_drive;
   logic                   rsp_dm_high_drive;
   logic [2:0]             rsp_mode_code;
   logic                   rsp_handshake_done;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index = CSR_INIT_HOLD;
   logic [CsrDataBits-1:0] csr_data = '0;

   quick_charge_voltage_requester_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_dip_code       (req_dip_code),
      .req_inc_pressed    (req_inc_pressed),
      .req_dec_pressed    (req_dec_pressed),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_dp_high_drive  (rsp_dp_high_drive),
      .rsp_dp_low_drive   (rsp_dp_low_drive),
      .rsp_dm_low_drive   (rsp_dm_low_drive),
      .rsp_dm_high_drive  (rsp_dm_high_drive),
      .rsp_mode_code      (rsp_mode_code),
      .rsp_handshake_done (rsp_handshake_done),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Ticks waiting to be driven, and drive patterns waiting to come back.
   item_type   tick_queue[$];
   result_type expected_drives[$];

   // Shadow copy of the sequencer and its timing registers.
   cfg_type              timing;
   phase_type            seq_phase = PH_HOLD;
   logic [TimerBits-1:0] tick_count = '0;
   logic [2:0]           cur_code = Code5V;
   logic [2:0]           pend_code = Code5V;
   logic [9:0]           held_ticks = '0;
   logic                 step_is_up = 1'b0;

   logic req_beat_taken = 1'b0;
   int   csr_writes = 0;
   int   stall_cycles = 0;
   logic no_idle = 1'b0;

   int error_count = 0;
   int ticks_sent = 0;
   int beats_checked = 0;
   int step_count = 0;
   int revert_count = 0;
   int settings_count = 0;

   // Random switch position and button levels, kept from one tick to the next.
   logic [2:0] switch_pos = CodeCont;
   logic       inc_level = 1'b0;
   logic       dec_level = 1'b0;

   initial begin
      timing.init_hold_ticks = InitHoldReset;
      timing.discharge_ticks = DischargeReset;
      timing.poll_ticks      = PollReset;
      timing.pulse_ticks     = PulseReset;
      timing.repeat_ticks    = RepeatReset;
   end

   // Counts one tick on the shared timer and tells whether the duration is over.
   function automatic logic timer_expired(input logic [11:0] dur);
      int unsigned lim;
      int unsigned cnt;
      lim = dur;
      if (lim > TimerMax) begin
         lim = TimerMax;
      end
      cnt = tick_count + 1;
      if (cnt > TimerMax) begin
         cnt = TimerMax;
      end
      tick_count = TimerBits'(cnt);
      return cnt >= lim;
   endfunction

   function automatic result_type advance_tick(input item_type it);
      logic       pressed;
      logic [3:0] pat;
      logic [2:0] shown;
      result_type r;
      case (seq_phase)
         PH_HOLD: begin
            if (timer_expired(timing.init_hold_ticks)) begin
               seq_phase = PH_DISCH;
               tick_count = '0;
            end
         end
         PH_DISCH: begin
            if (timer_expired(12'(timing.discharge_ticks))) begin
               cur_code = it.dip_code;
               seq_phase = PH_POLL;
               tick_count = '0;
            end
         end
         PH_REVERT: begin
            if (timer_expired(12'(timing.pulse_ticks))) begin
               cur_code = pend_code;
               seq_phase = PH_POLL;
               tick_count = '0;
            end
         end
         PH_PULSE: begin
            if (timer_expired(12'(timing.pulse_ticks))) begin
               seq_phase = PH_CONT;
               tick_count = '0;
            end
         end
         PH_CONT: begin
            if (timer_expired(12'(timing.pulse_ticks))) begin
               seq_phase = PH_HELD;
               held_ticks = '0;
               tick_count = '0;
            end
         end
         PH_HELD: begin
            pressed = step_is_up ? it.inc_pressed : it.dec_pressed;
            if (!pressed) begin
               seq_phase = PH_POLL;
               tick_count = '0;
            end else begin
               // A repeat time of zero behaves like one; the count wraps at ten bits.
               held_ticks = held_ticks + 10'd1;
               if (held_ticks >= timing.repeat_ticks || held_ticks == '0) begin
                  held_ticks = '0;
                  seq_phase = PH_PULSE;
                  tick_count = '0;
               end
            end
         end
         default: begin
            seq_phase = PH_POLL;
            if (timer_expired(12'(timing.poll_ticks))) begin
               tick_count = '0;
               if (it.dip_code != cur_code && cur_code == CodeCont) begin
                  pend_code = it.dip_code;
                  seq_phase = PH_REVERT;
               end else begin
                  cur_code = it.dip_code;
                  if (cur_code == CodeCont && (it.inc_pressed || it.dec_pressed)) begin
                     // The step-up button wins when both are pressed.
                     step_is_up = it.inc_pressed;
                     seq_phase = PH_PULSE;
                  end
               end
            end
         end
      endcase

      r.handshake_done = 1'b1;
      shown = cur_code;
      pat = 4'b0001;
      case (seq_phase)
         PH_HOLD:   r.handshake_done = 1'b0;
         PH_DISCH:  r.handshake_done = 1'b0;
         PH_REVERT: shown = Code5V;
         PH_PULSE:  shown = step_is_up ? Code20V : Code12V;
         PH_CONT:   shown = CodeCont;
         default:   ;
      endcase
      // Bits are {dm_high, dm_low, dp_low, dp_high}.
      if (seq_phase == PH_HOLD) begin
         pat = 4'b1001;
      end else if (seq_phase != PH_DISCH) begin
         case (shown)
            Code9V:   pat = 4'b1011;
            Code12V:  pat = 4'b1001;
            Code20V:  pat = 4'b1111;
            CodeCont: pat = 4'b1101;
            default:  pat = 4'b0001;
         endcase
      end
      r.dp_high_drive = pat[0];
      r.dp_low_drive  = pat[1];
      r.dm_low_drive  = pat[2];
      r.dm_high_drive = pat[3];
      r.mode_code     = shown;
      return r;
   endfunction

   // Driver: inputs move on the falling edge.
   always @(negedge clock) begin
      item_type tick_in;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_beat_taken) begin
            if (tick_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 28)) begin
               tick_in = tick_queue.pop_front();
               req_valid       <= 1'b1;
               req_dip_code    <= tick_in.dip_code;
               req_inc_pressed <= tick_in.inc_pressed;
               req_dec_pressed <= tick_in.dec_pressed;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= no_idle || $urandom_range(0, 99) >= 28;
      end
   end

   // Monitor: checks result beats, then predicts for the tick taken at this edge.
   always @(posedge clock) begin
      item_type   tick_in;
      result_type got;
      result_type want;
      phase_type  prior_phase;
      if (reset) begin
         req_beat_taken <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_dp_high_drive, rsp_dp_low_drive, rsp_dm_low_drive, rsp_dm_high_drive,
                   rsp_mode_code, rsp_handshake_done};
            beats_checked++;
            if (expected_drives.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("Result beat %0d arrived with no tick waiting for it", beats_checked);
               end
            end else begin
               want = expected_drives.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("Beat %0d: expected drives %b%b%b%b mode %0d done %b",
                              beats_checked, want.dp_high_drive, want.dp_low_drive,
                              want.dm_low_drive, want.dm_high_drive, want.mode_code,
                              want.handshake_done);
                     $display("         got      drives %b%b%b%b mode %0d done %b",
                              got.dp_high_drive, got.dp_low_drive, got.dm_low_drive,
                              got.dm_high_drive, got.mode_code, got.handshake_done);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            tick_in = {req_dip_code, req_inc_pressed, req_dec_pressed};
            prior_phase = seq_phase;
            expected_drives.push_back(advance_tick(tick_in));
            ticks_sent++;
            if (seq_phase == PH_PULSE && prior_phase != PH_PULSE) begin
               step_count++;
            end
            if (seq_phase == PH_REVERT && prior_phase != PH_REVERT) begin
               revert_count++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INIT_HOLD: timing.init_hold_ticks = csr_data[11:0];
               CSR_DISCHARGE: timing.discharge_ticks = csr_data[7:0];
               CSR_POLL:      timing.poll_ticks = csr_data[7:0];
               CSR_PULSE:     timing.pulse_ticks = csr_data[7:0];
               CSR_REPEAT:    timing.repeat_ticks = csr_data[9:0];
               default:       ;
            endcase
            csr_writes <= csr_writes + 1;
         end
         req_beat_taken <= req_valid && req_ready;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == StallLimit) begin
         $display("Watchdog: no handshake for %0d cycles", StallLimit);
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic queue_tick(input logic [2:0] dip, input logic inc, input logic dec);
      item_type it;
      it.dip_code = dip;
      it.inc_pressed = inc;
      it.dec_pressed = dec;
      tick_queue.push_back(it);
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (tick_queue.size() != 0 || req_valid || expected_drives.size() != 0);
   endtask

   // Rewrites all five timing registers once the block has gone quiet.
   task automatic load_timing(input logic [11:0] hold_t, input logic [7:0] disch_t,
                              input logic [7:0] poll_t, input logic [7:0] pulse_t,
                              input logic [9:0] rep_t);
      csr_index_type          regs[5];
      logic [CsrDataBits-1:0] vals[5];
      int                     seen;
      regs = '{CSR_INIT_HOLD, CSR_DISCHARGE, CSR_POLL, CSR_PULSE, CSR_REPEAT};
      vals = '{hold_t, 12'(disch_t), 12'(poll_t), 12'(pulse_t), 12'(rep_t)};
      wait_drained();
      for (int i = 0; i < 5; i++) begin
         seen = csr_writes;
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= vals[i];
         do begin
            @(negedge clock);
         end while (csr_writes == seen);
      end
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   // Mostly a switch that sits on continuous mode with buttons held for a while,
   // plus some ticks with every field random.
   task automatic random_ticks(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 11) == 0) begin
            switch_pos = ($urandom_range(0, 9) < 6) ? CodeCont : 3'($urandom_range(0, 7));
         end
         if ($urandom_range(0, 7) == 0) begin
            inc_level = !inc_level;
         end
         if ($urandom_range(0, 7) == 0) begin
            dec_level = !dec_level;
         end
         if ($urandom_range(0, 9) == 0) begin
            queue_tick(3'($urandom), 1'($urandom), 1'($urandom));
         end else begin
            queue_tick(switch_pos, inc_level, dec_level);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Shortest handshake, a poll on every tick and one-tick steps.
      load_timing(12'd0, 8'd1, 8'd0, 8'd1, 10'd0);
      queue_tick(CodeCont, 1'b1, 1'b1);
      queue_tick(Code12V, 1'b0, 1'b0);
      queue_tick(3'd0, 1'b1, 1'b0);
      queue_tick(Code20V, 1'b0, 1'b1);
      queue_tick(3'd2, 1'b0, 1'b0);
      queue_tick(Code9V, 1'b1, 1'b1);
      queue_tick(3'd4, 1'b0, 1'b0);
      queue_tick(Code5V, 1'b0, 1'b0);
      // Step up, then keep the button held so the step repeats.
      queue_tick(CodeCont, 1'b1, 1'b0);
      queue_tick(CodeCont, 1'b1, 1'b0);
      queue_tick(CodeCont, 1'b1, 1'b0);
      queue_tick(CodeCont, 1'b1, 1'b0);
      queue_tick(Code9V, 1'b1, 1'b0);
      queue_tick(Code9V, 1'b1, 1'b0);
      queue_tick(Code9V, 1'b1, 1'b0);
      // Release while the step finishes, so the sequence goes back to polling in continuous mode.
      queue_tick(Code9V, 1'b0, 1'b0);
      queue_tick(Code9V, 1'b0, 1'b0);
      queue_tick(Code9V, 1'b0, 1'b0);
      // Step down, and both buttons at a poll.
      queue_tick(CodeCont, 1'b0, 1'b1);
      queue_tick(CodeCont, 1'b1, 1'b1);
      queue_tick(CodeCont, 1'b1, 1'b1);
      queue_tick(CodeCont, 1'b1, 1'b0);
      queue_tick(CodeCont, 1'b1, 1'b1);
      queue_tick(CodeCont, 1'b1, 1'b1);

      load_timing(12'd4095, 8'd255, 8'd0, 8'd0, 10'd0);
      random_ticks(200);
      load_timing(InitHoldReset, DischargeReset, 8'd255, 8'd255, 10'd1023);
      random_ticks(300);
      for (int k = 0; k < 4; k++) begin
         load_timing(12'($urandom), 8'($urandom), 8'($urandom_range(0, 8)),
                     8'($urandom_range(0, 6)), 10'($urandom_range(0, 20)));
         no_idle <= (k == 1);
         random_ticks(240);
      end

      wait_drained();
      repeat (TailCycles) @(posedge clock);
      $display("Drove %0d ticks under %0d timing settings; %0d result beats checked.",
               ticks_sent, settings_count, beats_checked);
      $display("The run saw %0d step pulses and %0d reverts to 5 V, %0d mismatches.",
               step_count, revert_count, error_count);
      if (error_count == 0 && expected_drives.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
design/qcvr_pkg.sv
design/qcvr_csr.sv
design/qcvr_ctrl.sv
design/quick_charge_voltage_requester_unit.sv
tb/tb.sv
